// ===== src/asrp_pkg.sv =====
// shared types, constants and helpers of the shelf rectangle packer
package asrp_pkg;

  localparam int DIM_W = 13;
  localparam int SUM_W = DIM_W + 1;
  localparam int POS_W = 12;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 4;

  localparam int MAX_DIM = 4096;
  localparam int WRITER_SLOTS_DEF = 64;

  localparam logic [DIM_W-1:0] ATLAS_WIDTH_RST = DIM_W'(1024);
  localparam logic [DIM_W-1:0] ATLAS_HEIGHT_RST = DIM_W'(1024);

  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = CFG_IDX_W'(1);

  localparam logic [STATUS_W-1:0] STATUS_PLACED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_ROOM = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 2'd2;

  // one writer: a shelf grows rightward, a column grows downward
  typedef struct packed {
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] right;
    logic [DIM_W-1:0] bottom;
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] limit;
    logic             is_column;
  } writer_t;

  typedef struct packed {
    logic [DIM_W-1:0] aw;
    logic [DIM_W-1:0] ah;
  } dims_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
  } result_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== src/asrp_cfg_if.sv =====
// register write channel
interface asrp_cfg_if import asrp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/asrp_rect_if.sv =====
// rectangle request channel
interface asrp_rect_if import asrp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] rect_width;
  logic [DIM_W-1:0] rect_height;

  modport source (output valid, output rect_width, output rect_height, input ready);
  modport sink (input valid, input rect_width, input rect_height, output ready);
endinterface

// ===== src/asrp_place_if.sv =====
// placement result channel
interface asrp_place_if import asrp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;

  modport source (output valid, output status, output pos_x, output pos_y, input ready);
  modport sink (input valid, input status, input pos_x, input pos_y, output ready);
endinterface

// ===== src/asrp_writer_mem.sv =====
// writer table: one write port, one read port with registered read data
module asrp_writer_mem import asrp_pkg::*; #(
  parameter int WRITER_SLOTS = WRITER_SLOTS_DEF,
  localparam int IDX_W = $clog2(WRITER_SLOTS)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  writer_t          wdata,
  input  logic [IDX_W-1:0] raddr,
  output writer_t          rdata
);

  writer_t mem [WRITER_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/asrp_ctrl.sv =====
// placement sequencer: table scan, selection, shelf/column update
module asrp_ctrl import asrp_pkg::*; #(
  parameter int WRITER_SLOTS = WRITER_SLOTS_DEF,
  localparam int IDX_W = $clog2(WRITER_SLOTS),
  localparam int CNT_W = $clog2(WRITER_SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  asrp_rect_if.sink        rect,
  input  dims_t            dims,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output writer_t          mem_wdata,
  output logic [IDX_W-1:0] mem_raddr,
  input  writer_t          mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_PLACE, S_UPDATE, S_FINISH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [DIM_W-1:0] floor;
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [CNT_W-1:0] iss_idx;
  logic             chk_vld;
  logic             found;
  logic [DIM_W-1:0] mw;
  logic [DIM_W-1:0] mh;
  logic [IDX_W-1:0] sel_idx;
  writer_t          sel;

  logic [DIM_W-1:0] sw;
  logic [DIM_W-1:0] sh;
  logic [SUM_W-1:0] sum_rw;
  logic [SUM_W-1:0] sum_bh;
  logic             fit;
  logic             take;
  logic [SUM_W-1:0] floor_sum;
  logic [DIM_W-1:0] sel_span;
  logic             add_col;
  logic             table_free;
  writer_t          col_entry;
  writer_t          adv_entry;

  // fit test and smallest-span rule on the entry coming out of the table
  always_comb begin
    sw = mem_rdata.right - mem_rdata.left;
    sh = mem_rdata.bottom - mem_rdata.top;
    sum_rw = {1'b0, mem_rdata.right} + {1'b0, w};
    sum_bh = {1'b0, mem_rdata.bottom} + {1'b0, h};
    if (mem_rdata.is_column) begin
      fit = (sum_bh <= {1'b0, mem_rdata.limit}) && (sw >= w);
    end else begin
      fit = (sum_rw <= {1'b0, mem_rdata.limit}) && (sh >= h);
    end
    take = !found || ((sw <= mw) && (sh <= mh)) || (sh < mh);
  end

  always_comb begin
    floor_sum = {1'b0, floor} + {1'b0, h};
    table_free = count < CNT_W'(WRITER_SLOTS);
    sel_span = sel.bottom - sel.top;
    add_col = !sel.is_column && ({1'b0, sel_span} >= {h, 1'b0}) && table_free;

    col_entry.top = sel.top + h;
    col_entry.right = sel.right + w;
    col_entry.bottom = sel.top + h;
    col_entry.left = sel.right;
    col_entry.limit = sel.bottom;
    col_entry.is_column = 1'b1;

    adv_entry = sel;
    if (sel.is_column) begin
      adv_entry.bottom = sel.bottom + h;
    end else begin
      adv_entry.right = sel.right + w;
    end
  end

  always_comb begin
    rect.ready = (state == S_IDLE);
    res_valid = (state == S_FINISH);
    mem_raddr = iss_idx[IDX_W-1:0];
    mem_we = 1'b0;
    mem_waddr = sel_idx;
    mem_wdata = adv_entry;
    case (state)
      S_PLACE: begin
        mem_we = add_col;
        mem_waddr = count[IDX_W-1:0];
        mem_wdata = col_entry;
      end
      S_UPDATE: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      floor <= '0;
      chk_vld <= 1'b0;
      found <= 1'b0;
      iss_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (rect.valid) begin
            w <= rect.rect_width;
            h <= rect.rect_height;
            iss_idx <= '0;
            chk_vld <= 1'b0;
            found <= 1'b0;
            if (rect.rect_width == '0 || rect.rect_height == '0 ||
                rect.rect_width > dims.aw) begin
              res <= '{status: STATUS_NO_ROOM, pos_x: '0, pos_y: '0};
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // read issued the cycle before its check
          if (chk_vld && fit && take) begin
            found <= 1'b1;
            mw <= (found && mw < sw) ? mw : sw;
            mh <= (found && mh < sh) ? mh : sh;
            sel <= mem_rdata;
            sel_idx <= iss_idx[IDX_W-1:0] - IDX_W'(1);
          end
          if (iss_idx < count) begin
            iss_idx <= iss_idx + CNT_W'(1);
            chk_vld <= 1'b1;
          end else begin
            chk_vld <= 1'b0;
            if (!chk_vld) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (found) begin
            state <= S_PLACE;
          end else if (floor_sum > {1'b0, dims.ah}) begin
            res <= '{status: STATUS_NO_ROOM, pos_x: '0, pos_y: '0};
            state <= S_FINISH;
          end else if (!table_free) begin
            res <= '{status: STATUS_TABLE_FULL, pos_x: '0, pos_y: '0};
            state <= S_FINISH;
          end else begin
            sel <= '{top: floor, right: '0, bottom: floor_sum[DIM_W-1:0],
                     left: '0, limit: dims.aw, is_column: 1'b0};
            sel_idx <= count[IDX_W-1:0];
            count <= count + CNT_W'(1);
            floor <= floor_sum[DIM_W-1:0];
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          res.status <= STATUS_PLACED;
          if (sel.is_column) begin
            res.pos_x <= sel.left[POS_W-1:0];
            res.pos_y <= sel.bottom[POS_W-1:0];
          end else begin
            res.pos_x <= sel.right[POS_W-1:0];
            res.pos_y <= sel.top[POS_W-1:0];
          end
          if (add_col) begin
            count <= count + CNT_W'(1);
          end
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(WRITER_SLOTS))
    else $error("writer count beyond table depth");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count >= $past(count))
    else $error("writer count went down");

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> CNT_W'($past(mem_waddr)) < count)
    else $error("table write outside filled entries");

  a_floor_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> floor >= $past(floor))
    else $error("shelf floor went down");

endmodule

// ===== src/atlas_shelf_rect_packer_top.sv =====
// Shelf rectangle packer for a texture atlas.
// Channels: rect takes one rectangle (rect_width, rect_height); place returns
// one result per rectangle (status, pos_x, pos_y) in request order; cfg writes
// atlas_width (index 0) and atlas_height (index 1), always ready, and is to be
// written only while no rectangle is in flight.
// A rectangle is taken only when the sequencer is idle. It then scans the n
// filled writer entries through the table memory, one read a cycle with each
// check in the cycle after its read, then decides, places and writes back; the
// next rectangle is taken once the result has left the sequencer. A refused new
// shelf skips the place and update states, and rejected sizes skip the scan.
// Only entries below the fill count are used, so the table needs no clearing:
// reset empties it at once and sets both atlas dimensions to 1024.
// The result sits in an output register; a new rectangle is taken while it
// waits, and the sequencer holds its next result until place is drained.
module atlas_shelf_rect_packer_top import asrp_pkg::*; #(
  parameter int WRITER_SLOTS = WRITER_SLOTS_DEF,
  localparam int IDX_W = $clog2(WRITER_SLOTS)
) (
  input  logic        clk,
  input  logic        rst,
  asrp_cfg_if.sink    cfg,
  asrp_rect_if.sink   rect,
  asrp_place_if.source place
);

  logic [DIM_W-1:0] atlas_width;
  logic [DIM_W-1:0] atlas_height;
  dims_t            dims;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             out_valid;
  result_t          out_res;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  writer_t          mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  writer_t          mem_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width <= ATLAS_WIDTH_RST;
      atlas_height <= ATLAS_HEIGHT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ATLAS_WIDTH: atlas_width <= cfg.data;
        REG_ATLAS_HEIGHT: atlas_height <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  assign dims.aw = clamp_dim(atlas_width);
  assign dims.ah = clamp_dim(atlas_height);

  // output register parts the sequencer from the receiver
  assign res_ready = !out_valid || place.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign place.valid = out_valid;
  assign place.status = out_res.status;
  assign place.pos_x = out_res.pos_x;
  assign place.pos_y = out_res.pos_y;

  asrp_ctrl #(.WRITER_SLOTS(WRITER_SLOTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .rect      (rect),
    .dims      (dims),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  asrp_writer_mem #(.WRITER_SLOTS(WRITER_SLOTS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== test/tb.sv =====
// testbench of the shelf rectangle packer: directed and random rectangles checked against a predictor
module tb;
  import asrp_pkg::*;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int TAIL_CYCLES = 100;
  localparam int MAX_PRINTED = 30;

  typedef struct {
    int unsigned top;
    int unsigned right;
    int unsigned bottom;
    int unsigned left;
    int unsigned lim;
    bit          column;
  } slot_t;

  typedef struct {
    int unsigned w;
    int unsigned h;
    int          gap;
  } rect_req_t;

  logic clk;
  logic rst;

  asrp_cfg_if   cfg ();
  asrp_rect_if  rect ();
  asrp_place_if place ();

  atlas_shelf_rect_packer_top dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .rect  (rect),
    .place (place)
  );

  // predictor state
  slot_t       slots [SLOTS];
  int unsigned slot_count = 0;
  int unsigned shelf_floor_y = 0;
  int unsigned atlas_w = 1024;
  int unsigned atlas_h = 1024;

  rect_req_t rects_to_send [$];
  result_t   placements_due [$];
  int        rects_in_flight = 0;
  int        mismatches = 0;
  int        cycles = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  bit        steady = 1'b0;
  bit        ready_steady = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned clamp_atlas(int unsigned v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  function automatic void add_slot(int unsigned top, int unsigned right, int unsigned bottom,
                                   int unsigned left, int unsigned lim, bit column);
    slots[slot_count] = '{top: top, right: right, bottom: bottom, left: left, lim: lim,
                          column: column};
    slot_count++;
  endfunction

  // works out where one rectangle lands and updates the writer table
  function automatic result_t place_rect(int unsigned w, int unsigned h);
    result_t     res;
    int unsigned aw, ah, sw, sh, mw, mh, px, py, t, sel;
    bit          found, fit;
    aw = clamp_atlas(atlas_w);
    ah = clamp_atlas(atlas_h);
    res.status = STATUS_NO_ROOM;
    res.pos_x = '0;
    res.pos_y = '0;
    if (w == 0 || h == 0 || w > aw) return res;
    found = 1'b0;
    sel = 0;
    mw = 0;
    mh = 0;
    for (int i = 0; i < slot_count; i++) begin
      if (slots[i].column) begin
        fit = slots[i].bottom + h <= slots[i].lim && slots[i].right - slots[i].left >= w;
      end else begin
        fit = slots[i].right + w <= slots[i].lim && slots[i].bottom - slots[i].top >= h;
      end
      if (fit) begin
        sw = slots[i].right - slots[i].left;
        sh = slots[i].bottom - slots[i].top;
        if (!found) begin
          found = 1'b1;
          mw = sw;
          mh = sh;
          sel = i;
        end
        // smallest span wins, a strictly lower height always does
        if ((sw <= mw && sh <= mh) || sh < mh) begin
          if (sw < mw) mw = sw;
          if (sh < mh) mh = sh;
          sel = i;
        end
      end
    end
    if (!found) begin
      if (shelf_floor_y + h > ah) return res;
      if (slot_count >= SLOTS) begin
        res.status = STATUS_TABLE_FULL;
        return res;
      end
      add_slot(shelf_floor_y, 0, shelf_floor_y + h, 0, aw, 1'b0);
      shelf_floor_y += h;
      sel = slot_count - 1;
    end
    if (slots[sel].column) begin
      px = slots[sel].left;
      py = slots[sel].bottom;
    end else begin
      px = slots[sel].right;
      py = slots[sel].top;
    end
    // tall shelf: open a column beneath the rectangle, unless the table is full
    if (!slots[sel].column && slots[sel].bottom - slots[sel].top >= 2 * h &&
        slot_count < SLOTS) begin
      t = slots[sel].top + h;
      add_slot(t, slots[sel].right + w, t, slots[sel].right, slots[sel].bottom, 1'b1);
    end
    if (slots[sel].column) begin
      slots[sel].bottom += h;
    end else begin
      slots[sel].right += w;
    end
    res.status = STATUS_PLACED;
    res.pos_x = POS_W'(px);
    res.pos_y = POS_W'(py);
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  function automatic int unsigned pick_dim(int unsigned cap);
    int unsigned r;
    r = $urandom_range(0, 999);
    if (r < 10) return 0;
    if (r < 600) return $urandom_range(1, (cap < 16) ? cap : 16);
    if (r < 900) return $urandom_range(1, (cap < 128) ? cap : 128);
    if (r < 985) return $urandom_range(1, cap);
    return cap;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < MAX_PRINTED) begin
      $display("place mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    end
    mismatches++;
  endtask

  task automatic send_rect(int unsigned w, int unsigned h);
    rects_to_send.push_back('{w: w, h: h, gap: steady ? 0 : pick_gap()});
    rects_in_flight++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (rects_in_flight != 0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= DIM_W'(value);
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_rects(int count, int unsigned aw, int unsigned ah);
    int unsigned w, h, last_h;
    last_h = 1;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      w = pick_dim(aw);
      // runs of equal heights fill a shelf before a new one opens
      if ($urandom_range(0, 4) == 0) begin
        h = last_h;
      end else begin
        h = pick_dim(ah);
      end
      if (h != 0) last_h = h;
      if ($urandom_range(0, 49) == 0) w = (aw < MAX_DIM) ? $urandom_range(aw + 1, MAX_DIM) : aw;
      send_rect(w, h);
    end
    steady = 1'b0;
  endtask

  task automatic atlas_phase(int unsigned aw, int unsigned ah, int count);
    wait_idle();
    cfg_write(REG_ATLAS_WIDTH, aw);
    cfg_write(REG_ATLAS_HEIGHT, ah);
    random_rects(count, aw, ah);
  endtask

  // predictor copy of the registers
  always @(posedge clk) begin
    if (rst) begin
      atlas_w = ATLAS_WIDTH_RST;
      atlas_h = ATLAS_HEIGHT_RST;
      slot_count = 0;
      shelf_floor_y = 0;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_ATLAS_WIDTH) begin
        atlas_w = cfg.data;
      end else if (cfg.index == REG_ATLAS_HEIGHT) begin
        atlas_h = cfg.data;
      end
    end
  end

  always @(posedge clk) begin : drive_rects
    rect_req_t item;
    if (rst) begin
      rect.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (rect.valid && rect.ready) begin
        placements_due.push_back(place_rect(rect.rect_width, rect.rect_height));
      end
      if (!rect.valid || rect.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          rect.valid <= 1'b0;
        end else if (rects_to_send.size() > 0) begin
          item = rects_to_send.pop_front();
          rect.valid       <= 1'b1;
          rect.rect_width  <= DIM_W'(item.w);
          rect.rect_height <= DIM_W'(item.h);
          gap_left = item.gap;
        end else begin
          rect.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_places
    result_t want;
    if (rst) begin
      place.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (place.valid && place.ready) begin
        if (placements_due.size() == 0) begin
          report_mismatch("result with no rectangle waiting, status", place.status, 0);
        end else begin
          want = placements_due.pop_front();
          rects_in_flight--;
          if (place.status !== want.status) report_mismatch("status", place.status, want.status);
          if (place.pos_x !== want.pos_x) report_mismatch("pos_x", place.pos_x, want.pos_x);
          if (place.pos_y !== want.pos_y) report_mismatch("pos_y", place.pos_y, want.pos_y);
        end
      end
      if (cycles % 1500 == 0) ready_steady = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        stall_left--;
        place.ready <= 1'b0;
      end else begin
        place.ready <= 1'b1;
        stall_left = ready_steady ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    int guard;
    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    rect.valid = 1'b0;
    rect.rect_width = '0;
    rect.rect_height = '0;
    place.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset size of 1024 x 1024
    send_rect(0, 5);
    send_rect(5, 0);
    send_rect(1025, 1);
    send_rect(4096, 4096);
    send_rect(1024, 1);
    send_rect(1, 1);
    send_rect(10, 8);
    send_rect(3, 4);
    send_rect(3, 2);
    send_rect(2, 2);
    send_rect(1, 1);
    send_rect(1, 1014);
    send_rect(1, 1);
    send_rect(5, 1);
    send_rect(1, 2);
    send_rect(2, 9);
    send_rect(1024, 1);
    send_rect(1, 1024);
    send_rect(1023, 2);
    send_rect(4095, 4095);

    // low shelves keep the floor down so the table can still be filled later
    wait_idle();
    cfg_write(REG_ATLAS_WIDTH, 4096);
    cfg_write(REG_ATLAS_HEIGHT, 4096);
    random_rects(200, 4096, 256);

    // one full-width shelf per transfer after the last result, until table or atlas height is full
    wait_idle();
    guard = 0;
    while (slot_count < SLOTS && shelf_floor_y < MAX_DIM && guard < 2 * SLOTS) begin
      send_rect(4096, 1);
      wait_idle();
      guard++;
    end
    send_rect(4096, 1);
    send_rect(4096, 2);
    send_rect(1, 1);

    atlas_phase(1, 1, 80);
    atlas_phase(4096, 4096, 110);
    atlas_phase(1, 4096, 80);
    atlas_phase($urandom_range(1, 4096), $urandom_range(1, 4096), 110);
    atlas_phase(2048, 3000, 80);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== atlas_shelf_rect_packer_top.f =====
src/asrp_pkg.sv
src/asrp_cfg_if.sv
src/asrp_rect_if.sv
src/asrp_place_if.sv
src/asrp_writer_mem.sv
src/asrp_ctrl.sv
src/atlas_shelf_rect_packer_top.sv
test/tb.sv
